// ===== design/fpulp_pkg.sv =====
// ----------------------------------------------------------------------------
// fpulp_pkg: shared types and constants of the ULP error monitor
// Register indexes, IEEE double field masks and the ordered-key helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package fpulp_pkg;

   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE       = 3'd0,
      CSR_REPORT_EXPRS = 3'd1,
      CSR_LOCALIZE     = 3'd2,
      CSR_THRESHOLD    = 3'd3
   } csr_index_type;

   localparam logic [63:0] SIGN_BIT     = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ONE_NAN_ULPS = 64'hFFFF_FFFF_FFFF_FFFE;

   function automatic logic is_nan(input logic [63:0] x);
      return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
   endfunction

   // Map a double onto a monotonic unsigned key; both zeros map to SIGN_BIT.
   function automatic logic [63:0] order_key(input logic [63:0] x);
      logic [63:0] mag;
      mag = {1'b0, x[62:0]};
      if (mag == 64'd0) begin
         return SIGN_BIT;
      end else if (x[63]) begin
         return SIGN_BIT - mag;
      end else begin
         return SIGN_BIT | mag;
      end
   endfunction

endpackage

`default_nettype wire

// ===== design/fp_error_ulp_monitor.sv =====
// Flow: an accepted req word passes ST_KEY, ST_DIST, one log per operand and ST_FIN;
//    ST_FIN waits while a stalled rsp word still holds the output register.
//    req_ready returns together with rsp_valid: no new word is taken before then.
// Each squaring step runs ST_MUL_A to ST_MUL_D on the single 32x32 multiplier,
//    FRAC_BITS+1 steps per log, two logs per word; ST_INC, ST_NORM, ST_LOG_END per log.
// Reset (synchronous): state and settings return to defaults, max/sum/count clear.
// ----------------------------------------------------------------------------
// fp_error_ulp_monitor: ULP distance and bits-of-error monitor
// Measures computed and local doubles against a reference, converts each ULP
// distance to log2(ulps+1) in fixed point and tracks max, sums and count.
// ----------------------------------------------------------------------------
`default_nettype none

module fp_error_ulp_monitor #(
   parameter int FRAC_BITS = 16,
   parameter int SUM_WIDTH = 48
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [63:0]                         req_shadow_bits,
   input  wire logic [63:0]                         req_computed_bits,
   input  wire logic [63:0]                         req_local_bits,
   input  wire logic                                req_force_req,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [63:0]                              rsp_ulps_error,
   output logic [63:0]                              rsp_ulps_local,
   output logic [FRAC_BITS+6:0]                     rsp_bits_error,
   output logic [FRAC_BITS+6:0]                     rsp_bits_local,
   output logic                                     rsp_update_expr,
   output logic                                     rsp_track_value,
   // register write channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [fpulp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [FRAC_BITS+6:0]                csr_wdata
);
   import fpulp_pkg::*;

   localparam int BITS_W = FRAC_BITS + 7;
   localparam int IT_W   = $clog2(FRAC_BITS + 1);
   localparam logic [BITS_W-1:0] THRESH_RESET = BITS_W'(5 << FRAC_BITS);
   localparam logic [IT_W-1:0]   IT_LAST      = IT_W'(FRAC_BITS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KEY,
      ST_DIST,
      ST_INC,
      ST_NORM,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_MUL_D,
      ST_LOG_END,
      ST_FIN
   } state_type;

   state_type state_ff;

   // configuration
   logic                 enable_ff, report_ff, localize_ff;
   logic [BITS_W-1:0]    thresh_ff;

   // accumulated state
   logic [BITS_W-1:0]    max_o_ff, max_l_ff;
   logic [SUM_WIDTH-1:0] sum_o_ff, sum_l_ff;
   logic [31:0]          count_ff;

   // operand capture
   logic [63:0]          shadow_ff, computed_ff, local_ff;
   logic                 force_ff;
   logic [63:0]          key_s_ff, key_c_ff, key_l_ff;
   logic                 nan_s_ff, nan_c_ff, nan_l_ff;
   logic                 which_ff;   // 0: computed value, 1: local value

   // results in progress
   logic [63:0]          ulps_e_ff, ulps_l_ff;
   logic [BITS_W-1:0]    bits_e_ff, bits_l_ff;

   // log2 unit
   logic [63:0]          m_ff;
   logic [5:0]           lz_ff;
   logic [2:0]           step_ff;
   logic [IT_W-1:0]      it_ff;
   logic [FRAC_BITS:0]   frac_ff;
   logic [63:0]          prod_ff;
   logic [127:0]         acc_ff;

   // output register
   logic                 rsp_valid_ff;
   logic [63:0]          rsp_ulps_e_ff, rsp_ulps_l_ff;
   logic [BITS_W-1:0]    rsp_bits_e_ff, rsp_bits_l_ff;
   logic                 rsp_upd_ff, rsp_trk_ff;

   // ---------------- distance unit (shared for both operands)
   logic [63:0] o_key;
   logic        o_nan;
   logic [64:0] diff_a, diff_b;
   logic [63:0] dist_in;

   always_comb begin
      o_key  = which_ff ? key_l_ff : key_c_ff;
      o_nan  = which_ff ? nan_l_ff : nan_c_ff;
      diff_a = {1'b0, key_s_ff} - {1'b0, o_key};
      diff_b = {1'b0, o_key} - {1'b0, key_s_ff};
      if (nan_s_ff && o_nan) begin
         dist_in = 64'd0;
      end else if (nan_s_ff || o_nan) begin
         dist_in = ONE_NAN_ULPS;
      end else if (diff_a[64]) begin
         dist_in = diff_b[63:0];
      end else begin
         dist_in = diff_a[63:0];
      end
   end

   // ---------------- log2 unit
   logic [64:0]  v_in;
   logic [63:0]  norm_shift;
   logic         norm_zero;
   logic [5:0]   norm_amt;
   logic [31:0]  mul_a, mul_b;
   logic [63:0]  prod_in;
   logic [127:0] sq_in;
   logic [63:0]  sq_hi;
   logic [63:0]  m_in;
   logic [5:0]   n_in;
   logic [FRAC_BITS+1:0] frac_inc;
   logic [BITS_W-1:0]    bits_in;

   assign v_in = {1'b0, (which_ff ? ulps_l_ff : ulps_e_ff)} + 65'd1;

   // binary-search normalize: one halving of the window per step
   always_comb begin
      case (step_ff)
         3'd0: begin
            norm_zero  = (m_ff[63:32] == 32'd0);
            norm_shift = m_ff << 32;
            norm_amt   = 6'd32;
         end
         3'd1: begin
            norm_zero  = (m_ff[63:48] == 16'd0);
            norm_shift = m_ff << 16;
            norm_amt   = 6'd16;
         end
         3'd2: begin
            norm_zero  = (m_ff[63:56] == 8'd0);
            norm_shift = m_ff << 8;
            norm_amt   = 6'd8;
         end
         3'd3: begin
            norm_zero  = (m_ff[63:60] == 4'd0);
            norm_shift = m_ff << 4;
            norm_amt   = 6'd4;
         end
         3'd4: begin
            norm_zero  = (m_ff[63:62] == 2'd0);
            norm_shift = m_ff << 2;
            norm_amt   = 6'd2;
         end
         default: begin
            norm_zero  = ~m_ff[63];
            norm_shift = m_ff << 1;
            norm_amt   = 6'd1;
         end
      endcase
   end

   // one 32x32 multiplier: low*low, low*high, high*high
   assign mul_a   = (state_ff == ST_MUL_C) ? m_ff[63:32] : m_ff[31:0];
   assign mul_b   = (state_ff == ST_MUL_A) ? m_ff[31:0]  : m_ff[63:32];
   assign prod_in = {32'd0, mul_a} * {32'd0, mul_b};

   assign sq_in = acc_ff + {prod_ff, 64'd0};
   assign sq_hi = sq_in[127:64];
   assign m_in  = sq_hi[63] ? sq_hi : {sq_hi[62:0], sq_in[63]};

   assign n_in     = 6'd63 - lz_ff;
   assign frac_inc = {1'b0, frac_ff} + (FRAC_BITS+2)'(1);
   assign bits_in  = BITS_W'({n_in, {FRAC_BITS{1'b0}}}) + BITS_W'(frac_inc >> 1);

   // ---------------- statistics update
   logic [BITS_W-1:0]    max_o_in, max_l_in, sel_new, sel_old;
   logic [SUM_WIDTH:0]   sum_o_add, sum_l_add;
   logic [SUM_WIDTH-1:0] sum_o_in, sum_l_in;
   logic                 upd_in, trk_in, fin_go;

   always_comb begin
      max_o_in  = (bits_e_ff > max_o_ff) ? bits_e_ff : max_o_ff;
      max_l_in  = (bits_l_ff > max_l_ff) ? bits_l_ff : max_l_ff;
      sum_o_add = {1'b0, sum_o_ff} + (SUM_WIDTH+1)'(bits_e_ff);
      sum_l_add = {1'b0, sum_l_ff} + (SUM_WIDTH+1)'(bits_l_ff);
      sum_o_in  = sum_o_add[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_o_add[SUM_WIDTH-1:0];
      sum_l_in  = sum_l_add[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_l_add[SUM_WIDTH-1:0];
      sel_new   = localize_ff ? max_l_in : max_o_in;
      sel_old   = localize_ff ? max_l_ff : max_o_ff;
      upd_in    = enable_ff && report_ff &&
                  (force_ff || (sel_new >= thresh_ff && sel_new > sel_old));
      trk_in    = enable_ff &&
                  (force_ff || (sel_new >= thresh_ff && sel_old < thresh_ff));
      fin_go    = !rsp_valid_ff || rsp_ready;
   end

   // ---------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b1;
         report_ff    <= 1'b1;
         localize_ff  <= 1'b0;
         thresh_ff    <= THRESH_RESET;
         max_o_ff     <= '0;
         max_l_ff     <= '0;
         sum_o_ff     <= '0;
         sum_l_ff     <= '0;
         count_ff     <= '0;
         which_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_ENABLE:       enable_ff   <= csr_wdata[0];
               CSR_REPORT_EXPRS: report_ff   <= csr_wdata[0];
               CSR_LOCALIZE:     localize_ff <= csr_wdata[0];
               CSR_THRESHOLD:    thresh_ff   <= csr_wdata;
               default: ;
            endcase
         end

         // a finishing word reloads the output register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  shadow_ff   <= req_shadow_bits;
                  computed_ff <= req_computed_bits;
                  local_ff    <= req_local_bits;
                  force_ff    <= req_force_req;
                  state_ff    <= ST_KEY;
               end
            end
            ST_KEY: begin
               key_s_ff <= order_key(shadow_ff);
               key_c_ff <= order_key(computed_ff);
               key_l_ff <= order_key(local_ff);
               nan_s_ff <= is_nan(shadow_ff);
               nan_c_ff <= is_nan(computed_ff);
               nan_l_ff <= is_nan(local_ff);
               which_ff <= 1'b0;
               state_ff <= ST_DIST;
            end
            ST_DIST: begin
               if (which_ff) begin
                  ulps_l_ff <= dist_in;
                  which_ff  <= 1'b0;
                  state_ff  <= ST_INC;
               end else begin
                  ulps_e_ff <= dist_in;
                  which_ff  <= 1'b1;
               end
            end
            ST_INC: begin
               m_ff     <= v_in[64] ? 64'hFFFF_FFFF_FFFF_FFFF : v_in[63:0];
               lz_ff    <= 6'd0;
               step_ff  <= 3'd0;
               state_ff <= ST_NORM;
            end
            ST_NORM: begin
               if (norm_zero) begin
                  m_ff  <= norm_shift;
                  lz_ff <= lz_ff + norm_amt;
               end
               if (step_ff == 3'd5) begin
                  it_ff    <= '0;
                  frac_ff  <= '0;
                  state_ff <= ST_MUL_A;
               end else begin
                  step_ff <= step_ff + 3'd1;
               end
            end
            ST_MUL_A: begin
               prod_ff  <= prod_in;
               state_ff <= ST_MUL_B;
            end
            ST_MUL_B: begin
               prod_ff  <= prod_in;
               acc_ff   <= {64'd0, prod_ff};
               state_ff <= ST_MUL_C;
            end
            ST_MUL_C: begin
               // cross term appears twice: add it shifted one extra place
               prod_ff  <= prod_in;
               acc_ff   <= acc_ff + {31'd0, prod_ff, 33'd0};
               state_ff <= ST_MUL_D;
            end
            ST_MUL_D: begin
               m_ff    <= m_in;
               frac_ff <= {frac_ff[FRAC_BITS-1:0], sq_hi[63]};
               if (it_ff == IT_LAST) begin
                  state_ff <= ST_LOG_END;
               end else begin
                  it_ff    <= it_ff + IT_W'(1);
                  state_ff <= ST_MUL_A;
               end
            end
            ST_LOG_END: begin
               if (which_ff) begin
                  bits_l_ff <= bits_in;
                  state_ff  <= ST_FIN;
               end else begin
                  bits_e_ff <= bits_in;
                  which_ff  <= 1'b1;
                  state_ff  <= ST_INC;
               end
            end
            ST_FIN: begin
               // hold until the output register is free
               if (fin_go) begin
                  if (enable_ff) begin
                     max_o_ff <= max_o_in;
                     max_l_ff <= max_l_in;
                     sum_o_ff <= sum_o_in;
                     sum_l_ff <= sum_l_in;
                     if (count_ff != 32'hFFFF_FFFF) begin
                        count_ff <= count_ff + 32'd1;
                     end
                  end
                  rsp_ulps_e_ff <= ulps_e_ff;
                  rsp_ulps_l_ff <= ulps_l_ff;
                  rsp_bits_e_ff <= bits_e_ff;
                  rsp_bits_l_ff <= bits_l_ff;
                  rsp_upd_ff    <= upd_in;
                  rsp_trk_ff    <= trk_in;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ulps_error  = rsp_ulps_e_ff;
   assign rsp_ulps_local  = rsp_ulps_l_ff;
   assign rsp_bits_error  = rsp_bits_e_ff;
   assign rsp_bits_local  = rsp_bits_l_ff;
   assign rsp_update_expr = rsp_upd_ff;
   assign rsp_track_value = rsp_trk_ff;

endmodule

`default_nettype wire

// ===== design/fpulp_checker.sv =====
// ----------------------------------------------------------------------------
// fpulp_checker: port-level checks of the ULP error monitor
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fpulp_checker #(
   parameter int FRAC_BITS = 16
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [63:0]          rsp_ulps_error,
   input wire logic [63:0]          rsp_ulps_local,
   input wire logic [FRAC_BITS+6:0] rsp_bits_error,
   input wire logic [FRAC_BITS+6:0] rsp_bits_local
);
   localparam logic [FRAC_BITS+6:0] BITS_MAX = (FRAC_BITS+7)'(64 << FRAC_BITS);

   // one word at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an accepted word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ulps_error)
         && $stable(rsp_bits_error))
      else $error("stalled response word changed or dropped");

   a_zero_ulps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ulps_error == 64'd0 |-> rsp_bits_error == '0)
      else $error("zero ULP distance with nonzero bits of error");

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bits_error <= BITS_MAX && rsp_bits_local <= BITS_MAX
         && (rsp_ulps_local != 64'd0 || rsp_bits_local == '0))
      else $error("bits of error out of range");

endmodule

bind fp_error_ulp_monitor fpulp_checker #(.FRAC_BITS(FRAC_BITS)) u_fpulp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_ulps_error (rsp_ulps_error),
   .rsp_ulps_local (rsp_ulps_local),
   .rsp_bits_error (rsp_bits_error),
   .rsp_bits_local (rsp_bits_local)
);

`default_nettype wire

// ===== tb/sv/fp_error_ulp_monitor_chk.sv =====
// ----------------------------------------------------------------------------
// fp_error_ulp_monitor_chk: response checker for the ULP error monitor
// Watches the register, request and response channels. It computes the
// expected ULP distances, bits of error and flags for every accepted request
// word, and compares each response word field by field in order.
// ----------------------------------------------------------------------------
module fp_error_ulp_monitor_chk #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [63:0]                     req_shadow_bits,
   input  logic [63:0]                     req_computed_bits,
   input  logic [63:0]                     req_local_bits,
   input  logic                            req_force_req,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [63:0]                     rsp_ulps_error,
   input  logic [63:0]                     rsp_ulps_local,
   input  logic [FRAC_BITS+6:0]            rsp_bits_error,
   input  logic [FRAC_BITS+6:0]            rsp_bits_local,
   input  logic                            rsp_update_expr,
   input  logic                            rsp_track_value,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [fpulp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [FRAC_BITS+6:0]            csr_wdata,
   output int                              fail_count,
   output int                              pending,
   output int                              words_checked,
   output int                              update_hits,
   output int                              track_hits
);
   import fpulp_pkg::*;

   localparam int BW = FRAC_BITS + 7;

   typedef struct packed {
      logic [63:0]   ulps_error;
      logic [63:0]   ulps_local;
      logic [BW-1:0] bits_error;
      logic [BW-1:0] bits_local;
      logic          update_expr;
      logic          track_value;
   } error_word_type;

   error_word_type expected_words[$];
   int             mismatches;
   int             checked;
   int             updates;
   int             tracks;

   logic          cfg_enable;
   logic          cfg_report;
   logic          cfg_localize;
   logic [BW-1:0] cfg_threshold;
   logic [BW-1:0] peak_overall;
   logic [BW-1:0] peak_local;

   function automatic logic nan_pattern(input logic [63:0] x);
      return (&x[62:52]) && (|x[51:0]);
   endfunction

   // Fold both zeros onto the midpoint so that -0 and +0 sit at the same place.
   function automatic logic [63:0] ordinal(input logic [63:0] x);
      logic [63:0] mag;
      mag = {1'b0, x[62:0]};
      if (mag == 64'd0) return 64'h8000_0000_0000_0000;
      return x[63] ? 64'h8000_0000_0000_0000 - mag : 64'h8000_0000_0000_0000 + mag;
   endfunction

   function automatic logic [63:0] ulp_distance(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] ka;
      logic [63:0] kb;
      if (nan_pattern(a) && nan_pattern(b)) return 64'd0;
      if (nan_pattern(a) || nan_pattern(b)) return ONE_NAN_ULPS;
      ka = ordinal(a);
      kb = ordinal(b);
      return (ka >= kb) ? ka - kb : kb - ka;
   endfunction

   // log2(ulps + 1) by repeated squaring of the normalized mantissa, rounded.
   function automatic logic [BW-1:0] bits_of_error(input logic [63:0] ulps);
      logic [63:0]        v;
      logic [63:0]        m;
      logic [127:0]       sq;
      logic [FRAC_BITS:0] frac;
      int                 n;
      v = ulps + 64'd1;
      if (v == 64'd0) v = '1;
      n = 63;
      while (n > 0 && !v[n]) n--;
      m = v << (63 - n);
      frac = '0;
      for (int i = 0; i <= FRAC_BITS; i++) begin
         sq = {64'd0, m} * {64'd0, m};
         frac = {frac[FRAC_BITS-1:0], sq[127]};
         m = sq[127] ? sq[127:64] : sq[126:63];
      end
      return BW'((64'(n) << FRAC_BITS) + ((64'(frac) + 64'd1) >> 1));
   endfunction

   task automatic predict_word();
      error_word_type w;
      logic [BW-1:0]  old_overall;
      logic [BW-1:0]  old_local;
      logic [BW-1:0]  sel_now;
      logic [BW-1:0]  sel_old;
      w.ulps_error = ulp_distance(req_shadow_bits, req_computed_bits);
      w.ulps_local = ulp_distance(req_shadow_bits, req_local_bits);
      w.bits_error = bits_of_error(w.ulps_error);
      w.bits_local = bits_of_error(w.ulps_local);
      w.update_expr = 1'b0;
      w.track_value = 1'b0;
      if (cfg_enable) begin
         old_overall = peak_overall;
         old_local = peak_local;
         if (w.bits_error > peak_overall) peak_overall = w.bits_error;
         if (w.bits_local > peak_local) peak_local = w.bits_local;
         sel_now = cfg_localize ? peak_local : peak_overall;
         sel_old = cfg_localize ? old_local : old_overall;
         w.update_expr = cfg_report && (req_force_req ||
                         (sel_now >= cfg_threshold && sel_now > sel_old));
         w.track_value = req_force_req || (sel_now >= cfg_threshold && sel_old < cfg_threshold);
      end
      expected_words.push_back(w);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at word %0d, %s: got %h, expected %h", checked, what, got, want);
      mismatches++;
   endtask

   task automatic compare_word();
      error_word_type w;
      if (expected_words.size() == 0) begin
         report_mismatch("word with nothing expected", rsp_ulps_error, 64'd0);
      end else begin
         w = expected_words.pop_front();
         if (rsp_ulps_error !== w.ulps_error)
            report_mismatch("ulps_error", rsp_ulps_error, w.ulps_error);
         if (rsp_ulps_local !== w.ulps_local)
            report_mismatch("ulps_local", rsp_ulps_local, w.ulps_local);
         if (rsp_bits_error !== w.bits_error)
            report_mismatch("bits_error", 64'(rsp_bits_error), 64'(w.bits_error));
         if (rsp_bits_local !== w.bits_local)
            report_mismatch("bits_local", 64'(rsp_bits_local), 64'(w.bits_local));
         if (rsp_update_expr !== w.update_expr)
            report_mismatch("update_expr", 64'(rsp_update_expr), 64'(w.update_expr));
         if (rsp_track_value !== w.track_value)
            report_mismatch("track_value", 64'(rsp_track_value), 64'(w.track_value));
         if (w.update_expr) updates++;
         if (w.track_value) tracks++;
      end
      checked++;
   endtask

   // Publish counts after this edge's predict and compare, on the nonblocking
   // side so the stimulus never races them.
   always @(posedge clock) begin
      if (reset) begin
         expected_words.delete();
         cfg_enable = 1'b1;
         cfg_report = 1'b1;
         cfg_localize = 1'b0;
         cfg_threshold = BW'(5 << FRAC_BITS);
         peak_overall = '0;
         peak_local = '0;
         mismatches = 0;
         checked = 0;
         updates = 0;
         tracks = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLE:       cfg_enable = csr_wdata[0];
               CSR_REPORT_EXPRS: cfg_report = csr_wdata[0];
               CSR_LOCALIZE:     cfg_localize = csr_wdata[0];
               CSR_THRESHOLD:    cfg_threshold = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_word();
         if (rsp_valid && rsp_ready) compare_word();
      end
      fail_count <= mismatches;
      pending <= expected_words.size();
      words_checked <= checked;
      update_hits <= updates;
      track_hits <= tracks;
   end

endmodule

// ===== tb/sv/fp_error_ulp_monitor_tb.sv =====
// ----------------------------------------------------------------------------
// fp_error_ulp_monitor_tb: testbench top of the ULP error monitor
// Drives directed and random double triples in bursts while the response
// side stalls on its own pattern, steps the registers through several
// settings between phases, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module fp_error_ulp_monitor_tb;
   import fpulp_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int BW = FRAC_BITS + 7;
   localparam logic [BW-1:0] THRESH_TOP = BW'(64 << FRAC_BITS);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd6;
   localparam int PHASE_WORDS = 160;

   localparam logic [63:0] POS_ZERO = 64'h0000_0000_0000_0000;
   localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
   localparam logic [63:0] POS_INF  = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] NEG_INF  = 64'hFFF0_0000_0000_0000;
   localparam logic [63:0] QNAN     = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] ONE_D    = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] MAX_FIN  = 64'h7FEF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MIN_SUB  = 64'h0000_0000_0000_0001;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [63:0]          req_shadow_bits = '0;
   logic [63:0]          req_computed_bits = '0;
   logic [63:0]          req_local_bits = '0;
   logic                 req_force_req = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [63:0]          rsp_ulps_error;
   logic [63:0]          rsp_ulps_local;
   logic [BW-1:0]        rsp_bits_error;
   logic [BW-1:0]        rsp_bits_local;
   logic                 rsp_update_expr;
   logic                 rsp_track_value;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [BW-1:0]        csr_wdata = '0;

   int fail_count;
   int pending;
   int words_checked;
   int update_hits;
   int track_hits;
   int words_sent = 0;
   int burst_left = 0;
   int ready_hold = 0;
   int settings_run = 1;

   always #1 clock = ~clock;

   fp_error_ulp_monitor #(.FRAC_BITS(FRAC_BITS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_shadow_bits(req_shadow_bits), .req_computed_bits(req_computed_bits),
      .req_local_bits(req_local_bits), .req_force_req(req_force_req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_ulps_error(rsp_ulps_error), .rsp_ulps_local(rsp_ulps_local),
      .rsp_bits_error(rsp_bits_error), .rsp_bits_local(rsp_bits_local),
      .rsp_update_expr(rsp_update_expr), .rsp_track_value(rsp_track_value),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   fp_error_ulp_monitor_chk #(.FRAC_BITS(FRAC_BITS)) u_chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_shadow_bits(req_shadow_bits), .req_computed_bits(req_computed_bits),
      .req_local_bits(req_local_bits), .req_force_req(req_force_req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_ulps_error(rsp_ulps_error), .rsp_ulps_local(rsp_ulps_local),
      .rsp_bits_error(rsp_bits_error), .rsp_bits_local(rsp_bits_local),
      .rsp_update_expr(rsp_update_expr), .rsp_track_value(rsp_track_value),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending), .words_checked(words_checked),
      .update_hits(update_hits), .track_hits(track_hits)
   );

   // Receiver: alternate ready stretches with stalls, mostly short, some long.
   always @(posedge clock) begin
      if (ready_hold == 0) begin
         if (rsp_ready) begin
            rsp_ready <= 1'b0;
            ready_hold <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 120)
                                                      : $urandom_range(1, 6);
         end else begin
            rsp_ready <= 1'b1;
            ready_hold <= $urandom_range(1, 400);
         end
      end else begin
         ready_hold <= ready_hold - 1;
      end
   end

   function automatic logic [63:0] rand_double();
      logic        sign;
      logic [10:0] expo;
      logic [51:0] mant;
      sign = 1'($urandom_range(0, 1));
      mant = 52'({$urandom, $urandom});
      expo = 11'($urandom_range(1, 2046));
      case ($urandom_range(0, 11))
         0: return {$urandom, $urandom};
         1: return {sign, 63'd0};
         2: return {sign, 11'h7FF, 52'd0};
         3: return {sign, 11'h7FF, (mant == 52'd0) ? 52'd1 : mant};
         4: return {sign, 11'h000, mant};
         5: return {sign, 11'h7FE, mant};
         6, 7: expo = 11'($urandom_range(1000, 1050));
         default: ;
      endcase
      return {sign, expo, mant};
   endfunction

   // Move a pattern by a random number of steps, from one ULP to whole decades.
   function automatic logic [63:0] perturb(input logic [63:0] base);
      logic [63:0] delta;
      delta = 64'($urandom_range(1, 4096));
      case ($urandom_range(0, 9))
         0: return base;
         1: return rand_double();
         2: return {~base[63], base[62:0]};
         3, 4: delta = 64'($urandom_range(1, 16));
         5, 6: delta = {$urandom, $urandom} >> $urandom_range(0, 63);
         default: ;
      endcase
      return $urandom_range(0, 1) ? base + delta : base - delta;
   endfunction

   task automatic issue_op(input logic [63:0] shadow, input logic [63:0] computed,
                           input logic [63:0] approx, input logic force_bit);
      req_valid <= 1'b1;
      req_shadow_bits <= shadow;
      req_computed_bits <= computed;
      req_local_bits <= approx;
      req_force_req <= force_bit;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (burst_left == 0) begin
         // drop valid for a random gap before the next burst
         req_valid <= 1'b0;
         repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 160))
            @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end else begin
         burst_left--;
      end
   endtask

   task automatic run_random(input int count);
      logic [63:0] shadow;
      repeat (count) begin
         shadow = rand_double();
         issue_op(shadow, perturb(shadow), perturb(shadow), ($urandom_range(0, 7) == 0));
      end
   endtask

   // Hold the request side until every expected word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [BW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic next_setting(input logic en, input logic rep, input logic loc,
                               input logic [BW-1:0] thresh);
      drain();
      // upper bits of the one-bit registers must be ignored
      write_reg(CSR_ENABLE, {(BW-1)'($urandom), en});
      write_reg(CSR_REPORT_EXPRS, {(BW-1)'($urandom), rep});
      write_reg(CSR_LOCALIZE, {(BW-1)'($urandom), loc});
      write_reg(CSR_THRESHOLD, thresh);
      settings_run++;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words on the reset settings
      issue_op(POS_ZERO, POS_ZERO, POS_ZERO, 1'b0);
      issue_op(POS_ZERO, NEG_ZERO, NEG_ZERO, 1'b0);
      issue_op(QNAN, 64'hFFFF_FFFF_FFFF_FFFF, QNAN, 1'b0);
      issue_op(ONE_D, ONE_D + 64'd1, ONE_D + 64'd2, 1'b0);
      issue_op(ONE_D, ONE_D - 64'd3, ONE_D + 64'd7, 1'b1);
      issue_op(QNAN, ONE_D, POS_ZERO, 1'b0);
      issue_op(ONE_D, QNAN, ONE_D, 1'b0);
      issue_op(POS_INF, NEG_INF, POS_INF, 1'b0);
      issue_op(MIN_SUB, NEG_ZERO | MIN_SUB, NEG_ZERO, 1'b0);
      issue_op(MAX_FIN, NEG_ZERO | MAX_FIN, POS_INF, 1'b0);
      issue_op(64'hFFFF_FFFF_FFFF_FFFF, POS_ZERO, 64'h7FF0_0000_0000_0001, 1'b1);
      issue_op(NEG_ZERO, MIN_SUB, NEG_ZERO | MIN_SUB, 1'b0);
      issue_op(ONE_D, ONE_D ^ 64'h000F_FFFF_FFFF_FFFF, ONE_D, 1'b1);
      issue_op(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
               64'h5555_5555_5555_5554, 1'b0);
      issue_op(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
               64'hAAAA_AAAA_AAAA_AAAB, 1'b0);
      issue_op(NEG_INF, NEG_ZERO | MAX_FIN, POS_INF, 1'b0);
      issue_op(64'h7FF0_0000_0000_0001, 64'hFFF8_0000_0000_0000, MAX_FIN, 1'b1);

      next_setting(1'b1, 1'b1, 1'b0, '0);
      run_random(PHASE_WORDS);
      next_setting(1'b1, 1'b1, 1'b1, BW'(20 << FRAC_BITS));
      run_random(PHASE_WORDS);
      next_setting(1'b0, 1'b1, 1'b0, BW'(2 << FRAC_BITS));
      run_random(PHASE_WORDS);
      next_setting(1'b1, 1'b0, 1'b0, THRESH_TOP);
      run_random(PHASE_WORDS);
      next_setting(1'b1, 1'b1, 1'b0, BW'($urandom_range(0, 64 << FRAC_BITS)));
      write_reg(CSR_SPARE, '1);
      run_random(PHASE_WORDS);
      next_setting(1'b1, 1'b1, 1'b1, THRESH_TOP);
      run_random(PHASE_WORDS);
      next_setting(1'b1, 1'b1, 1'b0, '1);
      run_random(PHASE_WORDS);

      drain();
      repeat (200) @(posedge clock);
      $display("covered %0d words over %0d register settings, %0d results checked",
               words_sent, settings_run, words_checked);
      $display("flags expected: %0d expression updates, %0d value tracks",
               update_hits, track_hits);
      if (fail_count == 0) begin
         $display("PASS fp_error_ulp_monitor");
      end else begin
         $display("FAIL fp_error_ulp_monitor");
      end
      $finish;
   end

   initial begin
      #6000000;
      $display("timeout with %0d words still expected", pending);
      $display("FAIL fp_error_ulp_monitor");
      $finish;
   end

endmodule
